[sv/i2ccd_pkg.sv]
// Shared types and constants for the two-wire bus clock divider search.
`timescale 1ns / 1ps

package i2ccd_pkg;

	localparam int DIVIDEND_W = 32;
	localparam int DIVISOR_W  = 22;
	localparam int REQ_W      = 22;
	localparam int SRC_W      = 29;
	localparam int RATE_W     = 29;
	localparam int CFG_DATA_W = 32;

	localparam int CLOCK_PRESCALE = 10;
	// floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
	localparam logic [DIVIDEND_W-1:0] PRESCALE_RECIP = 32'hCCCCCCCD;
	localparam int                    PRESCALE_SHIFT = 35;

	localparam logic [DIVIDEND_W-1:0] CLK_HZ_RESET   = 32'd24000000;
	localparam logic [REQ_W-1:0]      MAX_RATE_RESET = 22'd400000;

	typedef enum logic [0:0] {
		REG_INPUT_CLOCK = 1'b0,
		REG_MAX_RATE    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_FOUND   = 2'd0,
		ST_INVALID = 2'd1,
		ST_CLAMPED = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		DSEL_REQ  = 1'b0,
		DSEL_RATE = 1'b1
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DIVR,
		S_DCHK,
		S_NSET,
		S_MUL,
		S_CMP,
		S_RSTART,
		S_RDIV,
		S_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic     req_load;
		logic     div_start;
		div_sel_t div_sel;
		logic     src_load;
		logic     dvd_load;
		logic     n_clear;
		logic     n_inc;
		logic     m_load;
		logic     m_inc;
		logic     mul_load;
		logic     set_found;
		logic     set_clamp;
		logic     set_invalid;
		logic     rate_load;
		logic     emit;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic req_bad;
		logic dvd_zero;
		logic q_skip;
		logic n_last;
		logic m_last;
		logic hit;
		logic out_full;
	} dp_sts_t;

endpackage

[sv/i2ccd_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module i2ccd_div
	import i2ccd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/i2ccd_datapath.sv]
// Datapath: config registers, search registers, test multiplier, shared divider, output register.
`timescale 1ns / 1ps

module i2ccd_datapath
	import i2ccd_pkg::*;
#(
	parameter int N_MAX = 7,
	parameter int M_MAX = 15,
	localparam int NW = $clog2(N_MAX + 1),
	localparam int MW = $clog2(M_MAX + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [REQ_W-1:0]      requested_rate,
	input  logic                  out_stall,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	output logic                  out_valid,
	output logic [NW-1:0]         exponent_n,
	output logic [MW-1:0]         factor_m,
	output logic [RATE_W-1:0]     achieved_rate,
	output logic [1:0]            status
);

	// (req+1) << n, then times (m+1)
	localparam int KW = REQ_W + 1 + N_MAX;
	localparam int PW = KW + MW + 1;

	logic [DIVIDEND_W-1:0] clk_hz_q;
	logic [REQ_W-1:0]      max_rate_q;
	logic [REQ_W-1:0]      req_q;
	logic [SRC_W-1:0]      src_q;
	logic [SRC_W-1:0]      dvd_q;
	logic [NW-1:0]         n_q;
	logic [MW-1:0]         m_q;
	logic [PW-1:0]         prod_q;
	logic [RATE_W-1:0]     rate_q;
	status_t               st_q;

	logic                  out_valid_q;
	logic [NW-1:0]         out_n_q;
	logic [MW-1:0]         out_m_q;
	logic [RATE_W-1:0]     out_rate_q;
	status_t               out_st_q;

	logic [DIVIDEND_W-1:0]   div_dividend;
	logic [DIVISOR_W-1:0]    div_divisor;
	logic                    div_done;
	logic [DIVIDEND_W-1:0]   div_quo;
	logic [SRC_W-1:0]        q_start;
	logic [KW-1:0]           k_val;
	logic [MW:0]             m_plus1;
	logic [2*DIVIDEND_W-1:0] src_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q   <= CLK_HZ_RESET;
			max_rate_q <= MAX_RATE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INPUT_CLOCK: clk_hz_q   <= cfg_data;
				REG_MAX_RATE:    max_rate_q <= cfg_data[REQ_W-1:0];
				default: ;
			endcase
		end
	end

	assign m_plus1 = {1'b0, m_q} + 1'b1;

	// source clock = input clock / 10 by reciprocal multiply
	assign src_prod = (2*DIVIDEND_W)'(clk_hz_q) * (2*DIVIDEND_W)'(PRESCALE_RECIP);

	always_comb begin
		unique case (cmd.div_sel)
			DSEL_REQ: begin
				div_dividend = DIVIDEND_W'(src_q);
				div_divisor  = req_q;
			end
			DSEL_RATE: begin
				div_dividend = DIVIDEND_W'(src_q);
				div_divisor  = DIVISOR_W'(m_plus1);
			end
		endcase
	end

	i2ccd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign q_start = dvd_q >> n_q;
	assign k_val   = KW'({1'b0, req_q} + 1'b1) << n_q;

	always_ff @(posedge clk) begin
		if (cmd.req_load)
			req_q <= requested_rate;
		if (cmd.src_load)
			src_q <= src_prod[PRESCALE_SHIFT +: SRC_W];
		if (cmd.dvd_load)
			dvd_q <= div_quo[SRC_W-1:0];
		if (cmd.mul_load)
			prod_q <= PW'(m_plus1) * PW'(k_val);
		if (cmd.rate_load)
			rate_q <= RATE_W'(div_quo >> n_q);

		if (cmd.set_invalid) begin
			n_q    <= '0;
			m_q    <= '0;
			rate_q <= '0;
			st_q   <= ST_INVALID;
		end else begin
			if (cmd.n_clear)
				n_q <= '0;
			else if (cmd.n_inc)
				n_q <= n_q + 1'b1;
			if (cmd.set_clamp) begin
				m_q  <= MW'(M_MAX);
				st_q <= ST_CLAMPED;
			end else if (cmd.m_load) begin
				m_q <= MW'(q_start - 1'b1);
			end else if (cmd.m_inc) begin
				m_q <= m_q + 1'b1;
			end
			if (cmd.set_found)
				st_q <= ST_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_n_q    <= n_q;
			out_m_q    <= m_q;
			out_rate_q <= rate_q;
			out_st_q   <= st_q;
		end
	end

	always_comb begin
		sts.div_done = div_done;
		sts.req_bad  = (req_q == '0) || (req_q > max_rate_q);
		sts.dvd_zero = (dvd_q == '0);
		sts.q_skip   = (q_start == '0) || (q_start > SRC_W'(M_MAX + 1));
		sts.n_last   = (n_q == NW'(N_MAX));
		sts.m_last   = (m_q == MW'(M_MAX));
		// floor(src/((m+1)*2^n)) <= req  <=>  src < (m+1)*(req+1)*2^n
		sts.hit      = PW'(src_q) < prod_q;
		sts.out_full = out_valid_q && out_stall;
	end

	assign out_valid     = out_valid_q;
	assign exponent_n    = out_n_q;
	assign factor_m      = out_m_q;
	assign achieved_rate = out_rate_q;
	assign status        = out_st_q;

endmodule

[sv/i2ccd_ctrl.sv]
// Controller state machine sequencing the divider search.
`timescale 1ns / 1ps

module i2ccd_ctrl
	import i2ccd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = DSEL_REQ;
		in_stall    = (state_q != S_IDLE);

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.req_load = 1'b1;
					cmd.src_load = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.req_bad) begin
					cmd.set_invalid = 1'b1;
					state_d         = S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_REQ;
					state_d       = S_DIVR;
				end
			end
			S_DIVR: begin
				if (sts.div_done) begin
					cmd.dvd_load = 1'b1;
					state_d      = S_DCHK;
				end
			end
			S_DCHK: begin
				if (sts.dvd_zero) begin
					cmd.set_invalid = 1'b1;
					state_d         = S_FINISH;
				end else begin
					cmd.n_clear = 1'b1;
					state_d     = S_NSET;
				end
			end
			S_NSET: begin
				// start of m range is below zero or above M_MAX: skip this n
				if (sts.q_skip) begin
					if (sts.n_last) begin
						cmd.set_clamp = 1'b1;
						state_d       = S_RSTART;
					end else begin
						cmd.n_inc = 1'b1;
					end
				end else begin
					cmd.m_load = 1'b1;
					state_d    = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = S_CMP;
			end
			S_CMP: begin
				if (sts.hit) begin
					cmd.set_found = 1'b1;
					state_d       = S_RSTART;
				end else if (!sts.m_last) begin
					cmd.m_inc = 1'b1;
					state_d   = S_MUL;
				end else if (sts.n_last) begin
					cmd.set_clamp = 1'b1;
					state_d       = S_RSTART;
				end else begin
					cmd.n_inc = 1'b1;
					state_d   = S_NSET;
				end
			end
			S_RSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_RATE;
				state_d       = S_RDIV;
			end
			S_RDIV: begin
				cmd.div_sel = DSEL_RATE;
				if (sts.div_done) begin
					cmd.rate_load = 1'b1;
					state_d       = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!sts.out_full) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[sv/i2c_clock_divider_search.sv]
// Top level of the two-wire bus clock divider search.
//
//  channel  direction  handshake             payload
//  cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//  in       in         in_valid/in_stall     requested_rate
//  out      out        out_valid/out_stall   exponent_n, factor_m, achieved_rate, status
//
// One request at a time; clock/10 is a reciprocal multiply, the other divisions share
// one 32-step divider. An invalid request goes to the result without a division; a zero
// divider ends the search after the first division. A valid request divides the source by
// the request, tries exponents n and (n, m) candidates in order, then divides for the rate.
// The result waits in an output register; a stalled output holds the next result back.
// Reset restores the clock and max-rate registers; cfg_ready is always high.
`timescale 1ns / 1ps

module i2c_clock_divider_search
	import i2ccd_pkg::*;
#(
	parameter int N_MAX = 7,
	parameter int M_MAX = 15
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [0:0]                   cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [REQ_W-1:0]             requested_rate,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [$clog2(N_MAX + 1)-1:0] exponent_n,
	output logic [$clog2(M_MAX + 1)-1:0] factor_m,
	output logic [RATE_W-1:0]            achieved_rate,
	output logic [1:0]                   status
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	i2ccd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	i2ccd_datapath #(
		.N_MAX (N_MAX),
		.M_MAX (M_MAX)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.requested_rate (requested_rate),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.exponent_n     (exponent_n),
		.factor_m       (factor_m),
		.achieved_rate  (achieved_rate),
		.status         (status)
	);

endmodule

[sv/i2ccd_checker.sv]
// Port-level checker for the divider search, bound to the top level.
`timescale 1ns / 1ps

module i2ccd_checker
	import i2ccd_pkg::*;
#(
	parameter int N_MAX = 7,
	parameter int M_MAX = 15
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [$clog2(N_MAX + 1)-1:0] exponent_n,
	input logic [$clog2(M_MAX + 1)-1:0] factor_m,
	input logic [RATE_W-1:0]            achieved_rate,
	input logic [1:0]                   status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(achieved_rate))
		else $error("stalled result changed or dropped");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("new request taken while search in progress");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_INVALID |->
			exponent_n == '0 && factor_m == '0 && achieved_rate == '0)
		else $error("invalid result carries nonzero fields");

	a_clamp_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_CLAMPED |->
			exponent_n == ($clog2(N_MAX + 1))'(N_MAX) && factor_m == ($clog2(M_MAX + 1))'(M_MAX))
		else $error("clamped result not at slowest pair");

endmodule

bind i2c_clock_divider_search i2ccd_checker #(
	.N_MAX (N_MAX),
	.M_MAX (M_MAX)
) u_i2ccd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.exponent_n    (exponent_n),
	.factor_m      (factor_m),
	.achieved_rate (achieved_rate),
	.status        (status)
);

[bench/divider_pick_checker.sv]
// Watches the divider search channels, predicts each result and compares it.
`timescale 1ns / 1ps

module divider_pick_checker
	import i2ccd_pkg::*;
#(
	parameter int N_MAX = 7,
	parameter int M_MAX = 15
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [0:0]                   cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [REQ_W-1:0]             requested_rate,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [$clog2(N_MAX + 1)-1:0] exponent_n,
	input  logic [$clog2(M_MAX + 1)-1:0] factor_m,
	input  logic [RATE_W-1:0]            achieved_rate,
	input  logic [1:0]                   status,
	output int                           mismatches,
	output int                           pending,
	output int                           found_total,
	output int                           rejected_total,
	output int                           clamped_total
);

	localparam int N_W = $clog2(N_MAX + 1);
	localparam int M_W = $clog2(M_MAX + 1);

	typedef struct packed {
		logic [N_W-1:0]    n;
		logic [M_W-1:0]    m;
		logic [RATE_W-1:0] rate;
		status_t           st;
	} divider_pick_t;

	logic [DIVIDEND_W-1:0] clk_hz;
	logic [REQ_W-1:0]      max_rate;
	divider_pick_t         pick_queue [$];

	function automatic divider_pick_t search_divider(input logic [REQ_W-1:0] req,
			input logic [DIVIDEND_W-1:0] clk_hz_now, input logic [REQ_W-1:0] max_now);
		divider_pick_t   pick;
		logic [31:0]     src;
		logic [31:0]     div;
		logic [31:0]     q;
		logic [31:0]     rate;
		longint unsigned n;
		longint unsigned m;
		src = clk_hz_now / 32'(CLOCK_PRESCALE);
		pick.n = '0;
		pick.m = '0;
		pick.rate = '0;
		pick.st = ST_INVALID;
		if (req == '0 || req > max_now)
			return pick;
		div = src / 32'(req);
		if (div == '0)
			return pick;
		for (n = 0; n <= N_MAX; n++) begin
			q = div >> n;
			// start would fall below zero for this exponent
			if (q == '0)
				continue;
			for (m = q - 1; m <= M_MAX; m++) begin
				rate = (src / 32'(m + 1)) >> n;
				if (rate <= 32'(req)) begin
					pick.n = N_W'(n);
					pick.m = M_W'(m);
					pick.rate = RATE_W'(rate);
					pick.st = ST_FOUND;
					return pick;
				end
			end
		end
		// nothing slow enough: slowest pair
		pick.n = N_W'(N_MAX);
		pick.m = M_W'(M_MAX);
		pick.rate = RATE_W'((src / 32'(M_MAX + 1)) >> N_MAX);
		pick.st = ST_CLAMPED;
		return pick;
	endfunction

	function automatic int field_differs(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want == got)
			return 0;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		divider_pick_t want;
		int            bad;
		if (!arst_n) begin
			clk_hz <= CLK_HZ_RESET;
			max_rate <= MAX_RATE_RESET;
			pick_queue.delete();
			pending <= 0;
			mismatches <= 0;
			found_total <= 0;
			rejected_total <= 0;
			clamped_total <= 0;
		end else begin
			bad = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_INPUT_CLOCK: clk_hz <= cfg_data;
					REG_MAX_RATE:    max_rate <= cfg_data[REQ_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pick_queue.push_back(search_divider(requested_rate, clk_hz, max_rate));
			if (out_valid && !out_stall) begin
				if (pick_queue.size() == 0) begin
					$error("result with no request outstanding");
					bad++;
				end else begin
					want = pick_queue.pop_front();
					bad += field_differs("exponent_n", want.n, exponent_n);
					bad += field_differs("factor_m", want.m, factor_m);
					bad += field_differs("achieved_rate", want.rate, achieved_rate);
					bad += field_differs("status", want.st, status);
					case (want.st)
						ST_FOUND:   found_total <= found_total + 1;
						ST_INVALID: rejected_total <= rejected_total + 1;
						default:    clamped_total <= clamped_total + 1;
					endcase
				end
			end
			pending <= pick_queue.size();
			mismatches <= mismatches + bad;
		end
	end

endmodule

[bench/i2c_clock_divider_search_tb.sv]
// Stimulus and verdict for the two-wire bus clock divider search.
`timescale 1ns / 1ps

module i2c_clock_divider_search_tb;
	import i2ccd_pkg::*;

	localparam int N_MAX = 7;
	localparam int M_MAX = 15;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int SETTLE_CYCLES = 400;
	localparam logic [REQ_W-1:0] RATE_TOP = '1;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [0:0]                   cfg_index = REG_INPUT_CLOCK;
	logic [CFG_DATA_W-1:0]        cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [REQ_W-1:0]             requested_rate = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [$clog2(N_MAX + 1)-1:0] exponent_n;
	logic [$clog2(M_MAX + 1)-1:0] factor_m;
	logic [RATE_W-1:0]            achieved_rate;
	logic [1:0]                   status;

	int mismatches;
	int pending;
	int found_total;
	int rejected_total;
	int clamped_total;

	int send_idle_pct = 25;
	int recv_idle_pct = 63;
	int requests_sent = 0;
	int settings_written = 0;
	int cycle_count = 0;

	// boundaries around the reset setting (source 2.4 MHz, max 400 kHz)
	logic [REQ_W-1:0] corner_rates [18] = '{
		22'd0, 22'd1, 22'd2, 22'd1102, 22'd1103, 22'd1104, 22'd1200, 22'd141177,
		22'd150000, 22'd150001, 22'd240000, 22'd300000, 22'd399999, 22'd400000,
		22'd400001, 22'h155555, 22'h2AAAAA, 22'h3FFFFF
	};

	i2c_clock_divider_search #(.N_MAX(N_MAX), .M_MAX(M_MAX)) uut (.*);

	divider_pick_checker #(.N_MAX(N_MAX), .M_MAX(M_MAX)) pick_check (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .requested_rate, .out_valid, .out_stall,
		.exponent_n, .factor_m, .achieved_rate, .status,
		.mismatches, .pending, .found_total, .rejected_total, .clamped_total
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL i2c_clock_divider_search");
			$finish;
		end
	end

	// valid is left high after acceptance; the next call decides whether it drops
	task automatic send_request(input logic [REQ_W-1:0] rate);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		requested_rate <= rate;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_settings(input logic [DIVIDEND_W-1:0] clk_hz,
			input logic [REQ_W-1:0] max_rate);
		cfg_valid <= 1'b1;
		cfg_index <= REG_INPUT_CLOCK;
		cfg_data <= clk_hz;
		do @(posedge clk); while (!cfg_ready);
		// upper data bits are junk for the max-rate register
		cfg_index <= REG_MAX_RATE;
		cfg_data <= {10'($urandom), max_rate};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_written++;
	endtask

	function automatic logic [REQ_W-1:0] pick_rate(input logic [REQ_W-1:0] max_rate);
		int unsigned      sel;
		logic [REQ_W-1:0] r;
		sel = $urandom_range(99);
		if (sel < 5)
			return '0;
		if (sel < 15 && max_rate != RATE_TOP)
			return REQ_W'($urandom_range(32'(max_rate) + 1, 32'(RATE_TOP)));
		r = REQ_W'($urandom_range(1, 32'(max_rate)));
		// log-spread slow rates to reach the clamp region
		if (sel < 40)
			r = r >> $urandom_range(0, REQ_W - 1);
		return (r == '0) ? REQ_W'(1) : r;
	endfunction

	initial begin
		logic [DIVIDEND_W-1:0] clk_hz;
		logic [REQ_W-1:0]      max_rate;
		int                    batch;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_rates[i])
			send_request(corner_rates[i]);
		drain();
		// source of 1 Hz: everything above 1 has a zero divider
		write_settings(32'd10, RATE_TOP);
		send_request(22'd1);
		send_request(22'd2);
		send_request(22'd3);
		send_request(RATE_TOP);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 25; recv_idle_pct = 63; end
				1: begin send_idle_pct = 63; recv_idle_pct = 25; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int s = 0; s < 6; s++) begin
				case (s)
					0: begin clk_hz = CLK_HZ_RESET; max_rate = MAX_RATE_RESET; batch = 80; end
					1: begin clk_hz = '1; max_rate = RATE_TOP; batch = 60; end
					2: begin clk_hz = 32'd10; max_rate = 22'd1; batch = 20; end
					3: begin clk_hz = 32'd10; max_rate = RATE_TOP; batch = 20; end
					4: begin
						clk_hz = $urandom_range(10, 32'hFFFF_FFFF);
						max_rate = REQ_W'($urandom_range(1, 32'(RATE_TOP)));
						batch = 80;
					end
					default: begin
						clk_hz = $urandom_range(1_000_000, 200_000_000);
						max_rate = REQ_W'($urandom_range(1, 32'(RATE_TOP)));
						batch = 80;
					end
				endcase
				write_settings(clk_hz, max_rate);
				for (int k = 0; k < batch; k++)
					send_request(pick_rate(max_rate));
				drain();
			end
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d rate requests across %0d clock/max-rate settings.",
			requests_sent, settings_written);
		$display("Results: %0d divider pairs found, %0d rejected, %0d clamped to slowest.",
			found_total, rejected_total, clamped_total);
		if (mismatches == 0 && pending == 0)
			$display("PASS i2c_clock_divider_search");
		else
			$display("FAIL i2c_clock_divider_search");
		$finish;
	end

endmodule
